### hw/rtl/triangle_plane_clipper_defines.svh
`ifndef TRIANGLE_PLANE_CLIPPER_DEFINES_SVH
`define TRIANGLE_PLANE_CLIPPER_DEFINES_SVH

// next-cycle check, masked during reset
`define TPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("triangle_plane_clipper check failed");

// next-cycle check, also active during reset
`define TPC_ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("triangle_plane_clipper check failed");

`endif

### hw/rtl/tpc_pkg.sv
`default_nettype none
package tpc_pkg;
  localparam int DIST_W   = 64;
  localparam int NORM_W   = 16;
  localparam int OFFSET_W = 48;
  localparam int COLOR_W  = 32;
  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_OFFSET = 4'd3;

  localparam logic [NORM_W-1:0] NORMAL_Z_RESET = 16'h4000;

  typedef enum logic [1:0] {
    NI_NONE,
    NI_ONE,
    NI_TWO,
    NI_ALL
  } ni_t;
endpackage
`default_nettype wire

### hw/rtl/triangle_plane_clipper.sv
// Clips one triangle per transfer against the plane dot(v, normal) >= plane_offset.
// A new triangle may be accepted every cycle while in_stall is low. A triangle
// that keeps all three vertices or one vertex yields one result; one that keeps
// two vertices yields two results, the first with out_last low, and the output
// stage holds that triangle until both are taken, stalling the pipeline behind
// it. Fully clipped triangles yield nothing. An input transfer passes stages a
// to e, then the restoring divider for the cut ratio, which spends one pipeline
// stage per quotient bit, then stages m and f. The configuration port is always ready.
`default_nettype none
module triangle_plane_clipper #(
  parameter int COORD_BITS      = 32,
  parameter int RATIO_FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [COORD_BITS-1:0]     in_v0_x,
  input  logic signed [COORD_BITS-1:0]     in_v0_y,
  input  logic signed [COORD_BITS-1:0]     in_v0_z,
  input  logic signed [COORD_BITS-1:0]     in_v1_x,
  input  logic signed [COORD_BITS-1:0]     in_v1_y,
  input  logic signed [COORD_BITS-1:0]     in_v1_z,
  input  logic signed [COORD_BITS-1:0]     in_v2_x,
  input  logic signed [COORD_BITS-1:0]     in_v2_y,
  input  logic signed [COORD_BITS-1:0]     in_v2_z,
  input  logic [tpc_pkg::COLOR_W-1:0]      in_color,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [COORD_BITS-1:0]     out_v0_x,
  output logic signed [COORD_BITS-1:0]     out_v0_y,
  output logic signed [COORD_BITS-1:0]     out_v0_z,
  output logic signed [COORD_BITS-1:0]     out_v1_x,
  output logic signed [COORD_BITS-1:0]     out_v1_y,
  output logic signed [COORD_BITS-1:0]     out_v1_z,
  output logic signed [COORD_BITS-1:0]     out_v2_x,
  output logic signed [COORD_BITS-1:0]     out_v2_y,
  output logic signed [COORD_BITS-1:0]     out_v2_z,
  output logic [tpc_pkg::COLOR_W-1:0]      out_color,
  output logic                             out_last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tpc_pkg::OFFSET_W-1:0]     cfg_wdata
);
  import tpc_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int R  = RATIO_FRAC_BITS;
  localparam int DW = CW + 1;
  localparam int HW = (DW > R) ? DW - R : 1;
  localparam int PW = CW + NORM_W;

  typedef logic [2:0][CW-1:0] vtx_t;
  typedef struct packed {
    vtx_t                p0;
    vtx_t                p1;
    vtx_t                p2;
    vtx_t                e0;
    vtx_t                e1;
    logic [COLOR_W-1:0]  color;
    ni_t                 ni;
  } pay_t;
  localparam int PAY_W = $bits(pay_t);

  // configuration
  logic signed [NORM_W-1:0]   nx_r, ny_r, nz_r;
  logic signed [OFFSET_W-1:0] off_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nx_r  <= '0;
      ny_r  <= '0;
      nz_r  <= NORMAL_Z_RESET;
      off_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NORMAL_X:     nx_r  <= cfg_wdata[NORM_W-1:0];
        REG_NORMAL_Y:     ny_r  <= cfg_wdata[NORM_W-1:0];
        REG_NORMAL_Z:     nz_r  <= cfg_wdata[NORM_W-1:0];
        REG_PLANE_OFFSET: off_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage ready chain
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_m, rdy_f;
  logic va_r, vb_r, vc_r, vd_r, vm_r, vf_r;
  logic [R+1:0] drdy;
  logic [R:0]   dv;

  // stage a: input register
  vtx_t               av_r [3];
  logic [COLOR_W-1:0] acol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (rdy_a) begin
      va_r <= in_valid;
    end
    if (rdy_a) begin
      av_r[0] <= {in_v0_z, in_v0_y, in_v0_x};
      av_r[1] <= {in_v1_z, in_v1_y, in_v1_x};
      av_r[2] <= {in_v2_z, in_v2_y, in_v2_x};
      acol_r  <= in_color;
    end
  end

  // stage b: products
  vtx_t                 bv_r [3];
  logic [COLOR_W-1:0]   bcol_r;
  logic signed [PW-1:0] bp_r [3][3];
  logic signed [PW-1:0] bp_nxt [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      bp_nxt[i][0] = $signed(av_r[i][0]) * nx_r;
      bp_nxt[i][1] = $signed(av_r[i][1]) * ny_r;
      bp_nxt[i][2] = $signed(av_r[i][2]) * nz_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (rdy_b) begin
      vb_r <= va_r;
    end
    if (rdy_b) begin
      bv_r   <= av_r;
      bcol_r <= acol_r;
      bp_r   <= bp_nxt;
    end
  end

  // stage c: partial sums
  vtx_t                     cv_r [3];
  logic [COLOR_W-1:0]       ccol_r;
  logic signed [DIST_W-1:0] cpa_r [3], cpb_r [3], cpa_nxt [3], cpb_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cpa_nxt[i] = DIST_W'(bp_r[i][0]) + DIST_W'(bp_r[i][1]);
      cpb_nxt[i] = DIST_W'(bp_r[i][2]) - DIST_W'(off_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (rdy_c) begin
      vc_r <= vb_r;
    end
    if (rdy_c) begin
      cv_r   <= bv_r;
      ccol_r <= bcol_r;
      cpa_r  <= cpa_nxt;
      cpb_r  <= cpb_nxt;
    end
  end

  // stage d: distances
  vtx_t               dv_r [3];
  logic [COLOR_W-1:0] dcol_r;
  logic [DIST_W-1:0]  dd_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (rdy_d) begin
      vd_r <= vc_r;
    end
    if (rdy_d) begin
      dv_r   <= cv_r;
      dcol_r <= ccol_r;
      for (int i = 0; i < 3; i++) begin
        dd_r[i] <= DIST_W'(cpa_r[i] + cpb_r[i]);
      end
    end
  end

  // stage e: classify and set up the divider
  logic [1:0] si0, si1, so0, so1;
  ni_t        ni;
  logic       ve_r;
  pay_t       epay_r, epay_nxt;
  logic [1:0][DIST_W-1:0] erem_r, eden_r, erem_nxt, eden_nxt;
  logic [DIST_W-1:0] ds1, de1;

  always_comb begin
    si0 = 2'd0; si1 = 2'd1; so0 = 2'd1; so1 = 2'd2; ni = NI_NONE;
    case ({!dd_r[0][DIST_W-1], !dd_r[1][DIST_W-1], !dd_r[2][DIST_W-1]})
      3'b111: begin ni = NI_ALL; si0 = 2'd0; si1 = 2'd1; end
      3'b100: begin ni = NI_ONE; si0 = 2'd0; so0 = 2'd1; so1 = 2'd2; end
      3'b010: begin ni = NI_ONE; si0 = 2'd1; so0 = 2'd0; so1 = 2'd2; end
      3'b001: begin ni = NI_ONE; si0 = 2'd2; so0 = 2'd0; so1 = 2'd1; end
      3'b110: begin ni = NI_TWO; si0 = 2'd0; si1 = 2'd1; so0 = 2'd2; end
      3'b101: begin ni = NI_TWO; si0 = 2'd0; si1 = 2'd2; so0 = 2'd1; end
      3'b011: begin ni = NI_TWO; si0 = 2'd1; si1 = 2'd2; so0 = 2'd0; end
      default: ni = NI_NONE;
    endcase
    ds1 = (ni == NI_TWO) ? dd_r[si1] : dd_r[si0];
    de1 = (ni == NI_TWO) ? dd_r[so0] : dd_r[so1];
    erem_nxt[0] = dd_r[si0];
    eden_nxt[0] = dd_r[si0] - dd_r[so0];
    erem_nxt[1] = ds1;
    eden_nxt[1] = ds1 - de1;
    epay_nxt.p0    = dv_r[si0];
    epay_nxt.p1    = dv_r[si1];
    epay_nxt.p2    = dv_r[2];
    epay_nxt.e0    = dv_r[so0];
    epay_nxt.e1    = (ni == NI_ONE) ? dv_r[so1] : dv_r[so0];
    epay_nxt.color = dcol_r;
    epay_nxt.ni    = ni;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (drdy[0]) begin
      ve_r <= vd_r && (ni != NI_NONE);
    end
    if (drdy[0]) begin
      epay_r <= epay_nxt;
      erem_r <= erem_nxt;
      eden_r <= eden_nxt;
    end
  end

  // divider pipeline, one quotient bit per stage
  logic [1:0][DIST_W-1:0] drem [R+1];
  logic [1:0][DIST_W-1:0] dden [R+1];
  logic [1:0][R-1:0]      dq   [R+1];
  logic [PAY_W-1:0]       dpay [R+1];

  assign dv[0]   = ve_r;
  assign drem[0] = erem_r;
  assign dden[0] = eden_r;
  assign dq[0]   = '0;
  assign dpay[0] = epay_r;

  for (genvar g = 0; g < R; g++) begin : g_div
    tpc_div_stage #(.Q_W(R), .PAY_W(PAY_W)) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .ld       (drdy[g+1]),
      .in_valid (dv[g]),
      .in_rem   (drem[g]),
      .in_den   (dden[g]),
      .in_q     (dq[g]),
      .in_pay   (dpay[g]),
      .out_valid(dv[g+1]),
      .out_rem  (drem[g+1]),
      .out_den  (dden[g+1]),
      .out_q    (dq[g+1]),
      .out_pay  (dpay[g+1])
    );
  end

  for (genvar g = 0; g <= R; g++) begin : g_rdy
    assign drdy[g] = !dv[g] || drdy[g+1];
  end
  assign drdy[R+1] = rdy_m;

  // stage m: cut products
  pay_t              mpay_r, dpay_last;
  logic [HW+R-1:0]   mh_r [2][3], mh_nxt [2][3];
  logic [2*R-1:0]    ml_r [2][3], ml_nxt [2][3];
  logic              mn_r [2][3], mn_nxt [2][3];
  vtx_t              ls [2], le [2];
  logic signed [CW:0] diff;
  logic [DW-1:0]     mag;
  logic [DW+R-1:0]   magx;

  assign dpay_last = pay_t'(dpay[R]);

  always_comb begin
    diff = '0; mag = '0; magx = '0;
    ls[0] = dpay_last.p0;
    ls[1] = (dpay_last.ni == NI_TWO) ? dpay_last.p1 : dpay_last.p0;
    le[0] = dpay_last.e0;
    le[1] = dpay_last.e1;
    for (int l = 0; l < 2; l++) begin
      for (int j = 0; j < 3; j++) begin
        diff = $signed({le[l][j][CW-1], le[l][j]}) - $signed({ls[l][j][CW-1], ls[l][j]});
        mag  = diff[CW] ? DW'(-diff) : DW'(diff);
        magx = {{R{1'b0}}, mag};
        mn_nxt[l][j] = diff[CW];
        mh_nxt[l][j] = (HW+R)'(magx[R +: HW]) * (HW+R)'(dq[R][l]);
        ml_nxt[l][j] = (2*R)'(magx[R-1:0]) * (2*R)'(dq[R][l]);
      end
    end
  end

  assign rdy_m = !vm_r || rdy_f;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else if (rdy_m) begin
      vm_r <= dv[R];
    end
    if (rdy_m) begin
      mpay_r <= dpay_last;
      mh_r   <= mh_nxt;
      ml_r   <= ml_nxt;
      mn_r   <= mn_nxt;
    end
  end

  // stage f: cut points and output hold
  pay_t                fpay_r;
  vtx_t                fc_r [2], fc_nxt [2], fs [2];
  logic                ph_r;
  logic [HW+R-1:0]     pmag;
  logic signed [CW+1:0] se, pe, res;

  always_comb begin
    pmag = '0; se = '0; pe = '0; res = '0;
    fs[0] = mpay_r.p0;
    fs[1] = (mpay_r.ni == NI_TWO) ? mpay_r.p1 : mpay_r.p0;
    for (int l = 0; l < 2; l++) begin
      for (int j = 0; j < 3; j++) begin
        pmag = mh_r[l][j] + (HW+R)'(ml_r[l][j] >> R);
        pe   = (CW+2)'(pmag);
        se   = (CW+2)'($signed(fs[l][j]));
        if (mn_r[l][j]) begin
          res = se - pe - (CW+2)'(|ml_r[l][j][R-1:0]);
        end else begin
          res = se + pe;
        end
        fc_nxt[l][j] = res[CW-1:0];
      end
    end
  end

  vtx_t o0, o1, o2;

  always_comb begin
    o0 = fpay_r.p0; o1 = fpay_r.p1; o2 = fpay_r.p2; out_last = 1'b1;
    case (fpay_r.ni)
      NI_ALL: begin o0 = fpay_r.p0; o1 = fpay_r.p1; o2 = fpay_r.p2; end
      NI_ONE: begin o0 = fpay_r.p0; o1 = fc_r[0]; o2 = fc_r[1]; end
      NI_TWO: begin
        if (ph_r) begin
          o0 = fc_r[0]; o1 = fc_r[1]; o2 = fpay_r.p1;
        end else begin
          o0 = fpay_r.p0; o1 = fc_r[0]; o2 = fpay_r.p1; out_last = 1'b0;
        end
      end
      default: out_last = 1'b1;
    endcase
  end

  assign rdy_f = !vf_r || (!out_stall && out_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
      ph_r <= 1'b0;
    end else if (rdy_f) begin
      vf_r <= vm_r;
      ph_r <= 1'b0;
    end else if (vf_r && !out_stall) begin
      ph_r <= 1'b1;
    end
    if (rdy_f) begin
      fpay_r <= mpay_r;
      fc_r   <= fc_nxt;
    end
  end

  assign rdy_d = !vd_r || drdy[0];
  assign rdy_c = !vc_r || rdy_d;
  assign rdy_b = !vb_r || rdy_c;
  assign rdy_a = !va_r || rdy_b;
  assign in_stall = !rdy_a;

  assign out_valid = vf_r;
  assign out_color = fpay_r.color;
  assign out_v0_x  = o0[0];
  assign out_v0_y  = o0[1];
  assign out_v0_z  = o0[2];
  assign out_v1_x  = o1[0];
  assign out_v1_y  = o1[1];
  assign out_v1_z  = o1[2];
  assign out_v2_x  = o2[0];
  assign out_v2_y  = o2[1];
  assign out_v2_z  = o2[2];
endmodule
`default_nettype wire

### hw/rtl/tpc_div_stage.sv
`default_nettype none
module tpc_div_stage #(
  parameter int Q_W   = 16,
  parameter int PAY_W = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            ld,
  input  logic                            in_valid,
  input  logic [1:0][tpc_pkg::DIST_W-1:0] in_rem,
  input  logic [1:0][tpc_pkg::DIST_W-1:0] in_den,
  input  logic [1:0][Q_W-1:0]             in_q,
  input  logic [PAY_W-1:0]                in_pay,
  output logic                            out_valid,
  output logic [1:0][tpc_pkg::DIST_W-1:0] out_rem,
  output logic [1:0][tpc_pkg::DIST_W-1:0] out_den,
  output logic [1:0][Q_W-1:0]             out_q,
  output logic [PAY_W-1:0]                out_pay
);
  import tpc_pkg::*;

  logic                   valid_r;
  logic [1:0][DIST_W-1:0] rem_r, rem_nxt, den_r;
  logic [1:0][Q_W-1:0]    q_r, q_nxt;
  logic [PAY_W-1:0]       pay_r;
  logic [DIST_W-1:0]      sh;

  always_comb begin
    sh = '0;
    for (int l = 0; l < 2; l++) begin
      sh = {in_rem[l][DIST_W-2:0], 1'b0};
      if (in_rem[l][DIST_W-1] || (sh >= in_den[l])) begin
        rem_nxt[l] = sh - in_den[l];
        q_nxt[l]   = {in_q[l][Q_W-2:0], 1'b1};
      end else begin
        rem_nxt[l] = sh;
        q_nxt[l]   = {in_q[l][Q_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ld) begin
      valid_r <= in_valid;
    end
    if (ld) begin
      rem_r <= rem_nxt;
      den_r <= in_den;
      q_r   <= q_nxt;
      pay_r <= in_pay;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_den   = den_r;
  assign out_q     = q_r;
  assign out_pay   = pay_r;
endmodule
`default_nettype wire

### hw/rtl/tpc_checker.sv
`default_nettype none
`include "triangle_plane_clipper_defines.svh"
module tpc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        out_last,
  input logic [tpc_pkg::COLOR_W-1:0] out_color
);
  `TPC_ASSERT_NEXT(a_hold_valid, out_valid && out_stall, out_valid)
  `TPC_ASSERT_NEXT(a_hold_color, out_valid && out_stall, $stable(out_color))
  `TPC_ASSERT_NEXT(a_second_follows, out_valid && !out_stall && !out_last, out_valid)
  `TPC_ASSERT_NEXT(a_second_color, out_valid && !out_stall && !out_last, $stable(out_color))
  `TPC_ASSERT_NEXT_ALWAYS(a_reset_idle, !rst_n, !out_valid)
endmodule

bind triangle_plane_clipper tpc_checker u_tpc_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_last (out_last),
  .out_color(out_color)
);
`default_nettype wire

### sim/testbench.sv
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tpc_pkg::*;

  localparam int CB = 32;
  localparam int RF = 16;
  localparam int DRAIN = RF + 16;
  localparam int LIMIT = 400000;
  localparam int N_PHASES = 8;
  localparam int PER_PHASE = 150;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd9;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_PASS, ROW_DROP} row_kind_t;

  typedef struct packed {
    logic [8:0][CB-1:0] c;
    logic [COLOR_W-1:0] color;
  } tri_in_t;

  typedef struct packed {
    logic [8:0][CB-1:0] c;
    logic [COLOR_W-1:0] color;
    logic               last;
  } tri_out_t;

  typedef struct packed {
    row_kind_t kind;
    tri_in_t   t;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  tri_in_t in_tri = '0;
  row_kind_t in_kind = ROW_PREDICT;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [CB-1:0] ov [9];
  logic [COLOR_W-1:0] out_color;
  logic out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [OFFSET_W-1:0] cfg_wdata = '0;

  logic signed [NORM_W-1:0] nx, ny, nz;
  logic signed [OFFSET_W-1:0] plane_off;
  tri_out_t clipped_q[$];
  int unsigned in_xfers = 0, cfg_xfers = 0, out_xfers = 0;
  int unsigned errors = 0, cycles = 0;
  int unsigned n_cut1 = 0, n_cut2 = 0, n_pass = 0, n_drop = 0;
  bit quiet = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  triangle_plane_clipper #(.COORD_BITS(CB), .RATIO_FRAC_BITS(RF)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_v0_x(in_tri.c[0]), .in_v0_y(in_tri.c[1]), .in_v0_z(in_tri.c[2]),
    .in_v1_x(in_tri.c[3]), .in_v1_y(in_tri.c[4]), .in_v1_z(in_tri.c[5]),
    .in_v2_x(in_tri.c[6]), .in_v2_y(in_tri.c[7]), .in_v2_z(in_tri.c[8]),
    .in_color(in_tri.color),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_v0_x(ov[0]), .out_v0_y(ov[1]), .out_v0_z(ov[2]),
    .out_v1_x(ov[3]), .out_v1_y(ov[4]), .out_v1_z(ov[5]),
    .out_v2_x(ov[6]), .out_v2_y(ov[7]), .out_v2_z(ov[8]),
    .out_color(out_color), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  function automatic longint plane_distance(longint x, longint y, longint z);
    return x * longint'(nx) + y * longint'(ny) + z * longint'(nz) - longint'(plane_off);
  endfunction

  function automatic logic [63:0] cut_ratio(longint ds, longint de);
    logic [63:0] den, r, q;
    logic top;
    den = ds - de;
    r = ds;
    q = '0;
    for (int i = 0; i < RF; i++) begin
      top = r[63];
      r = r << 1;
      q = q << 1;
      if (top || r >= den) begin
        r = r - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic void cut_vertex(input longint s[3], input longint e[3],
                                     input longint ds, input longint de,
                                     output longint r[3]);
    longint k, prod;
    k = longint'(cut_ratio(ds, de));
    for (int i = 0; i < 3; i++) begin
      prod = (e[i] - s[i]) * k;
      r[i] = s[i] + (prod >>> RF);
    end
  endfunction

  function automatic void push_tri(longint a[3], longint b[3], longint c[3],
                                   logic [COLOR_W-1:0] color, logic last);
    tri_out_t o;
    for (int j = 0; j < 3; j++) begin
      o.c[j] = a[j][CB-1:0];
      o.c[3+j] = b[j][CB-1:0];
      o.c[6+j] = c[j][CB-1:0];
    end
    o.color = color;
    o.last = last;
    clipped_q.push_back(o);
  endfunction

  function automatic void predict_clip(tri_in_t t);
    longint v[3][3], ins[3][3], outs[3][3], c0[3], c1[3];
    longint d, din[3], dout[3];
    int ni, no;
    ni = 0;
    no = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) v[i][j] = longint'(signed'(t.c[i*3+j]));
      d = plane_distance(v[i][0], v[i][1], v[i][2]);
      if (d >= 0) begin
        ins[ni] = v[i];
        din[ni] = d;
        ni++;
      end else begin
        outs[no] = v[i];
        dout[no] = d;
        no++;
      end
    end
    case (ni)
      0: n_drop++;
      3: begin
        push_tri(v[0], v[1], v[2], t.color, 1'b1);
        n_pass++;
      end
      1: begin
        cut_vertex(ins[0], outs[0], din[0], dout[0], c0);
        cut_vertex(ins[0], outs[1], din[0], dout[1], c1);
        push_tri(ins[0], c0, c1, t.color, 1'b1);
        n_cut1++;
      end
      default: begin
        cut_vertex(ins[0], outs[0], din[0], dout[0], c0);
        cut_vertex(ins[1], outs[0], din[1], dout[0], c1);
        push_tri(ins[0], c0, ins[1], t.color, 1'b0);
        push_tri(c0, c1, ins[1], t.color, 1'b1);
        n_cut2++;
      end
    endcase
  endfunction

  always @(posedge clk) begin
    tri_out_t got, want;
    if (!rst_n) begin
      nx <= '0;
      ny <= '0;
      nz <= NORMAL_Z_RESET;
      plane_off <= '0;
    end else begin
      cycles++;
      if (cycles > LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
      if (cfg_valid && cfg_ready) begin
        cfg_xfers++;
        case (cfg_index)
          REG_NORMAL_X:     nx <= cfg_wdata[NORM_W-1:0];
          REG_NORMAL_Y:     ny <= cfg_wdata[NORM_W-1:0];
          REG_NORMAL_Z:     nz <= cfg_wdata[NORM_W-1:0];
          REG_PLANE_OFFSET: plane_off <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        in_xfers++;
        case (in_kind)
          ROW_PASS: begin
            clipped_q.push_back({in_tri.c, in_tri.color, 1'b1});
            n_pass++;
          end
          ROW_DROP: n_drop++;
          default: predict_clip(in_tri);
        endcase
      end
      if (out_valid && !out_stall) begin
        out_xfers++;
        for (int i = 0; i < 9; i++) got.c[i] = ov[i];
        got.color = out_color;
        got.last = out_last;
        if (clipped_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result transfer %0d: %h", out_xfers, got);
        end else begin
          want = clipped_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              for (int i = 0; i < 9; i++)
                if (got.c[i] !== want.c[i])
                  $display("result %0d coord %0d: expected %h got %h",
                           out_xfers, i, want.c[i], got.c[i]);
              if (got.color !== want.color)
                $display("result %0d color: expected %h got %h",
                         out_xfers, want.color, got.color);
              if (got.last !== want.last)
                $display("result %0d last: expected %b got %b",
                         out_xfers, want.last, got.last);
            end
          end
        end
      end
    end
  end

  // receiver: stall in random bursts
  initial begin
    int burst;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 5);
        out_stall <= 1'b1;
        repeat (burst) @(negedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  // call at a falling edge; returns at the falling edge after the transfer
  task automatic send_tri(tri_in_t t, row_kind_t kind);
    int unsigned seen;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    seen = in_xfers;
    in_tri <= t;
    in_kind <= kind;
    in_valid <= 1'b1;
    do @(negedge clk); while (in_xfers == seen);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [OFFSET_W-1:0] val);
    int unsigned seen;
    @(negedge clk);
    seen = cfg_xfers;
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (cfg_xfers == seen);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (clipped_q.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  function automatic logic [CB-1:0] rand_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    endcase
  endfunction

  function automatic tri_in_t rand_tri();
    tri_in_t t;
    int mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++)
      t.c[i] = rand_coord(mode < 4 ? 0 : (mode == 4 ? $urandom_range(0, 2) : 2));
    t.color = $urandom;
    return t;
  endfunction

  function automatic tri_in_t mk(logic [CB-1:0] z0, logic [CB-1:0] z1, logic [CB-1:0] z2,
                                 logic [CB-1:0] xy, logic [COLOR_W-1:0] color);
    tri_in_t t;
    t.c = {z2, xy, ~xy, z1, ~xy, xy, z0, xy, xy};
    t.color = color;
    return t;
  endfunction

  row_t directed [] = '{
    '{ROW_PASS,    mk(32'h0, 32'h0, 32'h0, 32'h0, 32'h0)},
    '{ROW_PASS,    mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'hffffffff)},
    '{ROW_PASS,    mk(32'h0, 32'h1, 32'h7fffffff, 32'h80000000, 32'h5a5aa5a5)},
    '{ROW_DROP,    mk(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'h12345678, 32'h1)},
    '{ROW_DROP,    mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h2)},
    '{ROW_PREDICT, mk(32'h00010000, 32'hffff0000, 32'hfffe0000, 32'h00030000, 32'h3)},
    '{ROW_PREDICT, mk(32'h00010000, 32'h00020000, 32'hffff0000, 32'hfffd0000, 32'h4)},
    '{ROW_PREDICT, mk(32'h80000000, 32'hffffffff, 32'h7fffffff, 32'h7fffffff, 32'h5)},
    '{ROW_PREDICT, mk(32'h80000000, 32'h7fffffff, 32'h0, 32'h80000000, 32'h6)},
    '{ROW_PREDICT, mk(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h0, 32'h7)},
    '{ROW_PREDICT, mk(32'h0, 32'hffffffff, 32'h0, 32'h7fffffff, 32'h8)}
  };

  initial begin
    logic [NORM_W-1:0] n [3];
    logic [OFFSET_W-1:0] off;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_tri(directed[i].t, directed[i].kind);

    for (int p = 1; p < N_PHASES; p++) begin
      drain_results();
      case (p)
        1: begin
          n = '{16'h7fff, 16'h7fff, 16'h7fff};
          off = 48'h7fff_ffff_ffff;
        end
        2: begin
          n = '{16'h8000, 16'h8000, 16'h8000};
          off = 48'h8000_0000_0000;
        end
        3: begin
          n = '{16'h8000, 16'h7fff, 16'h0};
          off = '0;
        end
        default: begin
          foreach (n[i]) n[i] = 16'($urandom);
          off = {{16{1'b0}}, 32'($urandom)};
          off = {{16{off[31]}}, off[31:0]} <<< $urandom_range(0, 16);
        end
      endcase
      write_reg(REG_NORMAL_X, {32'($urandom), n[0]});
      write_reg(REG_NORMAL_Y, n[1]);
      write_reg(REG_NORMAL_Z, n[2]);
      write_reg(REG_PLANE_OFFSET, off);
      write_reg(REG_SPARE, {16'($urandom), 32'($urandom)});
      quiet = (p == N_PHASES - 1);
      for (int i = 0; i < (p < 3 ? 30 : PER_PHASE + 20); i++) send_tri(rand_tri(), ROW_PREDICT);
    end

    drain_results();
    $display("triangles sent %0d: %0d kept whole, %0d one-vertex cuts, %0d two-vertex cuts,",
             in_xfers, n_pass, n_cut1, n_cut2);
    $display("%0d fully clipped; %0d results checked over %0d plane settings",
             n_drop, out_xfers, N_PHASES);
    if (errors == 0 && clipped_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", errors);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire
